[hdl/brs_pkg.sv]
// brs_pkg: shared types and constants for the bilinear RGBA sampler.
// No dependencies; every other file of the block but brs_checker refers to it.
`timescale 1ns / 1ps

package brs_pkg;

    // Item kinds on the action port
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] RESET_DIM = 8'd128;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam int CHANNELS = 4;

    typedef struct packed {
        logic        is_sample;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [31:0] pixel;     // alpha, blue, green, red from msb down
        logic [14:0] sx;
        logic [14:0] sy;
    } brs_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } brs_q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_LAST
    } brs_back_state_t;

endpackage

[hdl/brs_fifo.sv]
// brs_fifo: short command queue between the front and back ends.
// Depends on brs_pkg for the word type and the queue depth.
`timescale 1ns / 1ps

module brs_fifo
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  brs_pkg::brs_item_t     push_word,
    input  logic                   pop,
    output brs_pkg::brs_item_t     head,
    output brs_pkg::brs_q_status_t status
);

    brs_pkg::brs_item_t slots [brs_pkg::QUEUE_DEPTH];

    logic [brs_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [brs_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [brs_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [brs_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [brs_pkg::QPTR_W:0]   count_reg;
    logic [brs_pkg::QPTR_W:0]   count_next;
    logic                       do_push;
    logic                       do_pop;

    assign status.full  = (count_reg == (brs_pkg::QPTR_W + 1)'(brs_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[hdl/brs_front.sv]
// brs_front: takes command words, drops writes that miss the pixel store,
// and queues the rest. Depends on brs_pkg.
`timescale 1ns / 1ps

module brs_front
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
)
(
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic [6:0]             write_col,
    input  logic [6:0]             write_row,
    input  logic [7:0]             write_red,
    input  logic [7:0]             write_green,
    input  logic [7:0]             write_blue,
    input  logic [7:0]             write_alpha,
    input  logic [14:0]            sample_x,
    input  logic [14:0]            sample_y,
    input  brs_pkg::brs_q_status_t q_status,
    output logic                   push,
    output brs_pkg::brs_item_t     push_word
);

    logic in_store;
    logic keep;

    // writes past the store are silently discarded
    assign in_store = (32'(write_col) < MAX_WIDTH) && (32'(write_row) < MAX_HEIGHT);
    assign keep     = (action == brs_pkg::ACT_SAMPLE) || in_store;
    assign busy     = q_status.full;
    assign push     = start && !q_status.full && keep;

    always_comb
    begin
        push_word.is_sample = (action == brs_pkg::ACT_SAMPLE);
        push_word.col       = write_col;
        push_word.row       = write_row;
        push_word.pixel     = {write_alpha, write_blue, write_green, write_red};
        push_word.sx        = sample_x;
        push_word.sy        = sample_y;
    end

endmodule

[hdl/brs_back.sv]
// brs_back: pixel store and the four-corner multiply-accumulate sequencer.
// Depends on brs_pkg; fed by brs_fifo.
`timescale 1ns / 1ps

module brs_back
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  brs_pkg::brs_item_t     head,
    input  brs_pkg::brs_q_status_t q_status,
    output logic                   pop,
    input  logic [7:0]             image_width,
    input  logic [7:0]             image_height,
    output logic                   result_valid,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue,
    output logic [7:0]             out_alpha
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = $clog2(MAX_WIDTH);
    localparam int RIW   = $clog2(MAX_HEIGHT);
    localparam int ONE_W = FRAC_BITS + 1;
    localparam int WW    = 2 * FRAC_BITS + 1;
    localparam int ACC_W = 2 * FRAC_BITS + 8;
    localparam logic [ONE_W-1:0] ONE     = ONE_W'(1) << FRAC_BITS;
    localparam logic [AW-1:0]    WIDTH_A = AW'(MAX_WIDTH);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    brs_pkg::brs_back_state_t state_reg;
    brs_pkg::brs_back_state_t state_next;

    logic [15:0]          c0_reg, c0_next;
    logic [15:0]          r0_reg, r0_next;
    logic [FRAC_BITS-1:0] fx_reg, fx_next;
    logic [FRAC_BITS-1:0] fy_reg, fy_next;
    logic [1:0]           step_reg, step_next;
    logic                 pend_reg, pend_next;     // a corner read landed this cycle
    logic                 inside_reg, inside_next;
    logic [WW-1:0]        wt_reg, wt_next;
    logic [ACC_W-1:0]     acc_reg  [brs_pkg::CHANNELS];
    logic [ACC_W-1:0]     acc_next [brs_pkg::CHANNELS];
    logic [ACC_W-1:0]     acc_sum  [brs_pkg::CHANNELS];
    logic                 result_valid_reg, result_valid_next;
    logic [7:0]           out_reg  [brs_pkg::CHANNELS];
    logic [7:0]           out_next [brs_pkg::CHANNELS];

    logic [7:0]           eff_w;
    logic [7:0]           eff_h;
    logic [15:0]          corner_col;
    logic [15:0]          corner_row;
    logic                 corner_in;
    logic [ONE_W-1:0]     wx;
    logic [ONE_W-1:0]     wy;
    logic [2*ONE_W-1:0]   wt_full;
    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;

    // dimensions larger than the store are clipped to it
    assign eff_w = (32'(image_width) > MAX_WIDTH) ? 8'(MAX_WIDTH) : image_width;
    assign eff_h = (32'(image_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : image_height;

    // step bit 0 picks the right column, bit 1 the lower row
    assign corner_col = c0_reg + {15'd0, step_reg[0]};
    assign corner_row = r0_reg + {15'd0, step_reg[1]};
    assign corner_in  = (corner_col < {8'd0, eff_w}) && (corner_row < {8'd0, eff_h});
    assign wx         = step_reg[0] ? {1'b0, fx_reg} : ONE - {1'b0, fx_reg};
    assign wy         = step_reg[1] ? {1'b0, fy_reg} : ONE - {1'b0, fy_reg};
    assign wt_full    = wx * wy;

    assign rd_addr = AW'(AW'(corner_row[RIW-1:0]) * WIDTH_A) + AW'(corner_col[CIW-1:0]);
    assign wr_addr = AW'(AW'(head.row) * WIDTH_A) + AW'(head.col);

    always_comb
    begin
        for (int ch = 0; ch < brs_pkg::CHANNELS; ch++)
        begin
            acc_sum[ch] = acc_reg[ch];
            if (pend_reg && inside_reg)
            begin
                acc_sum[ch] = acc_reg[ch]
                            + ACC_W'(wt_reg) * ACC_W'(rd_data_reg[8*ch +: 8]);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        c0_next           = c0_reg;
        r0_next           = r0_reg;
        fx_next           = fx_reg;
        fy_next           = fy_reg;
        step_next         = step_reg;
        pend_next         = 1'b0;
        inside_next       = inside_reg;
        wt_next           = wt_reg;
        result_valid_next = 1'b0;
        pop               = 1'b0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        for (int ch = 0; ch < brs_pkg::CHANNELS; ch++)
        begin
            acc_next[ch] = acc_sum[ch];
            out_next[ch] = out_reg[ch];
        end

        unique case (state_reg)
            brs_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (head.is_sample)
                    begin
                        c0_next   = 16'(head.sx) >> FRAC_BITS;
                        r0_next   = 16'(head.sy) >> FRAC_BITS;
                        fx_next   = FRAC_BITS'(head.sx);
                        fy_next   = FRAC_BITS'(head.sy);
                        step_next = 2'd0;
                        for (int ch = 0; ch < brs_pkg::CHANNELS; ch++)
                        begin
                            acc_next[ch] = '0;
                        end
                        state_next = brs_pkg::BK_ISSUE;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            end
            brs_pkg::BK_ISSUE:
            begin
                rd_en       = corner_in;
                pend_next   = 1'b1;
                inside_next = corner_in;
                wt_next     = WW'(wt_full);
                step_next   = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = brs_pkg::BK_LAST;
                end
            end
            brs_pkg::BK_LAST:
            begin
                for (int ch = 0; ch < brs_pkg::CHANNELS; ch++)
                begin
                    out_next[ch] = acc_sum[ch][2*FRAC_BITS +: 8];
                end
                result_valid_next = 1'b1;
                state_next        = brs_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = brs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= brs_pkg::BK_IDLE;
            step_reg         <= 2'd0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int ch = 0; ch < brs_pkg::CHANNELS; ch++)
            begin
                out_reg[ch] <= 8'd0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            for (int ch = 0; ch < brs_pkg::CHANNELS; ch++)
            begin
                out_reg[ch] <= out_next[ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg     <= c0_next;
        r0_reg     <= r0_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        inside_reg <= inside_next;
        wt_reg     <= wt_next;
        for (int ch = 0; ch < brs_pkg::CHANNELS; ch++)
        begin
            acc_reg[ch] <= acc_next[ch];
        end
    end

    // pixel store: one write or one read per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= head.pixel;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign result_valid = result_valid_reg;
    assign out_red      = out_reg[0];
    assign out_green    = out_reg[1];
    assign out_blue     = out_reg[2];
    assign out_alpha    = out_reg[3];

endmodule

[hdl/bilinear_rgba_sampler.sv]
// A sample occupies the back end until its result strobes: it is popped, then the four
// serial reads of the one-port pixel store are issued, then the final add; a pixel write
// retires as it is popped. A 4-word queue absorbs bursts meanwhile.
// busy rises only when the queue is full. Results cannot be stalled: one-cycle strobe.
// Reset (rst_n low, async) empties the queue, idles the sequencer and sets both dims to 128;
// the pixel store is not cleared and must be written before it is sampled.
`timescale 1ns / 1ps

module bilinear_rgba_sampler
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int FRAC_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [6:0]  write_col,
    input  logic [6:0]  write_row,
    input  logic [7:0]  write_red,
    input  logic [7:0]  write_green,
    input  logic [7:0]  write_blue,
    input  logic [7:0]  write_alpha,
    input  logic [14:0] sample_x,
    input  logic [14:0] sample_y,

    // result strobe
    output logic        result_valid,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    brs_pkg::brs_item_t     push_word;
    brs_pkg::brs_item_t     head;
    brs_pkg::brs_q_status_t q_status;
    logic                   push;
    logic                   pop;

    logic [7:0] image_width_reg;
    logic [7:0] image_width_next;
    logic [7:0] image_height_reg;
    logic [7:0] image_height_next;

    // Config is always taken at once; the user must see that it is only written while the block
    // is idle (the block itself does not enforce this), so the back end reads the registers live.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                brs_pkg::REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                brs_pkg::REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default:                   image_width_next  = image_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= brs_pkg::RESET_DIM;
            image_height_reg <= brs_pkg::RESET_DIM;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // Front end: accept and classify, drop out-of-store writes
    brs_front
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_front
    (
        .start       (start),
        .busy        (busy),
        .action      (action),
        .write_col   (write_col),
        .write_row   (write_row),
        .write_red   (write_red),
        .write_green (write_green),
        .write_blue  (write_blue),
        .write_alpha (write_alpha),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .q_status    (q_status),
        .push        (push),
        .push_word   (push_word)
    );

    // Queue keeps write/sample order, so a sample sees exactly the writes before it
    brs_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Back end: store writes and four-corner weighted sums
    brs_back
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .result_valid (result_valid),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha)
    );

endmodule

[hdl/brs_checker.sv]
// brs_checker: port-level checks on the sampler's result and config behavior.
// Bound to bilinear_rgba_sampler below; needs no package.
`timescale 1ns / 1ps

module brs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic [7:0] out_alpha,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // each sample occupies the back end until its strobe, so strobes are spaced apart
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid ##1 !result_valid ##1 !result_valid
                         ##1 !result_valid ##1 !result_valid)
        else $error("result strobes closer than six cycles");

    // result word only changes together with a strobe
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> $stable({out_red, out_green, out_blue, out_alpha}))
        else $error("result word changed without a strobe");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken at once");

endmodule

bind bilinear_rgba_sampler brs_checker u_brs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

[tb/tb_bilinear_rgba_sampler.sv]
// tb_bilinear_rgba_sampler: self-checking testbench for the bilinear RGBA sampler.
// Depends on hdl/brs_pkg.sv and hdl/bilinear_rgba_sampler.sv; reads no files.
`timescale 1ns / 1ps

module tb_bilinear_rgba_sampler;

    localparam int STORE_W     = 128;
    localparam int STORE_H     = 128;
    localparam int STORE_DEPTH = STORE_W * STORE_H;
    localparam int FRAC_BITS   = 8;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int NUM_PHASES  = 7;

    // Cycles to let queued pixel writes retire after the last result: covers a full queue
    // of 4 plus a sample in the back end, with margin.
    localparam int DRAIN_CYCLES = 40;
    // Cycles with no handshake of any kind before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    // One interpolated pixel, same lane order as the store: red in the low byte.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic        action      = brs_pkg::ACT_WRITE;
    logic [6:0]  write_col   = '0;
    logic [6:0]  write_row   = '0;
    logic [7:0]  write_red   = '0;
    logic [7:0]  write_green = '0;
    logic [7:0]  write_blue  = '0;
    logic [7:0]  write_alpha = '0;
    logic [14:0] sample_x    = '0;
    logic [14:0] sample_y    = '0;
    logic        result_valid;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic        cfg_index   = brs_pkg::REG_IMAGE_WIDTH;
    logic [7:0]  cfg_data    = '0;

    // Image shape and sender idle rate per phase. Phase 0 runs on the reset
    // dims; the others include zero width, over-range (saturating) values and 1x1.
    // phase_words is the word budget of each phase, fill-in writes included.
    logic [7:0] phase_width  [NUM_PHASES] = '{8'd128, 8'd7, 8'd0,   8'd1, 8'd255, 8'd128, 8'd12};
    logic [7:0] phase_height [NUM_PHASES] = '{8'd128, 8'd4, 8'd255, 8'd1, 8'd2,   8'd128, 8'd9};
    int         phase_idle   [NUM_PHASES] = '{36, 36, 50, 50, 50, 0, 0};
    int         phase_words  [NUM_PHASES] = '{90, 90, 30, 40, 60, 100, 90};
    string      chan_name    [4]          = '{"red", "green", "blue", "alpha"};

    // Words waiting to be driven; the head is the one on the ports while start is up.
    brs_pkg::brs_item_t pending_words [$];
    // Pixels the sampler still owes, oldest first.
    rgba_t       expected_pixels [$];

    // Predictor copy of the image and of the two dims registers.
    logic [31:0] image_mem [STORE_DEPTH];
    logic [7:0]  img_width  = brs_pkg::RESET_DIM;
    logic [7:0]  img_height = brs_pkg::RESET_DIM;
    // Generator view: which store entries hold a pixel already.
    bit          pixel_written [STORE_DEPTH];

    int idle_pct       = 36;
    int words_queued   = 0;
    int words_issued   = 0;
    int words_accepted = 0;
    int samples_taken  = 0;
    int writes_taken   = 0;
    int cfg_writes     = 0;
    int errors         = 0;
    int quiet_cycles   = 0;

    bilinear_rgba_sampler #(
        .MAX_WIDTH  (STORE_W),
        .MAX_HEIGHT (STORE_H),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .write_col    (write_col),
        .write_row    (write_row),
        .write_red    (write_red),
        .write_green  (write_green),
        .write_blue   (write_blue),
        .write_alpha  (write_alpha),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .result_valid (result_valid),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Dims above the store size saturate to the store size.
    function automatic int eff_dim(input logic [7:0] v, input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Bilinear blend of the up to four neighbors inside the image; exact sum,
    // then truncated by dropping 2*FRAC_BITS bits.
    function automatic rgba_t bilerp_pixel(input logic [14:0] sx, input logic [14:0] sy);
        int unsigned acc [4];
        int unsigned c0, r0, fx, fy, col, row, wgt;
        int          w_eff, h_eff, n, k;
        logic [31:0] word;
        logic [31:0] packed_res;
        c0    = sx >> FRAC_BITS;
        r0    = sy >> FRAC_BITS;
        fx    = sx & (ONE - 1);
        fy    = sy & (ONE - 1);
        w_eff = eff_dim(img_width, STORE_W);
        h_eff = eff_dim(img_height, STORE_H);
        for (k = 0; k < 4; k++)
        begin
            acc[k] = 0;
        end
        // n bit 0 picks the right column, bit 1 the lower row
        for (n = 0; n < 4; n++)
        begin
            col = c0 + (n & 1);
            row = r0 + (n >> 1);
            wgt = (((n & 1) != 0) ? fx : ONE - fx) * (((n >> 1) != 0) ? fy : ONE - fy);
            if (col < w_eff && row < h_eff)
            begin
                word = image_mem[row * STORE_W + col];
                for (k = 0; k < 4; k++)
                begin
                    acc[k] += wgt * word[8 * k +: 8];
                end
            end
        end
        for (k = 0; k < 4; k++)
        begin
            packed_res[8 * k +: 8] = 8'(acc[k] >> (2 * FRAC_BITS));
        end
        return rgba_t'(packed_res);
    endfunction

    // Pixel write; the sample fields carry noise that the block must ignore.
    task automatic queue_write(input int col, input int row, input logic [31:0] pix);
        brs_pkg::brs_item_t w;
        w.is_sample = 1'b0;
        w.col       = col[6:0];
        w.row       = row[6:0];
        w.pixel     = pix;
        w.sx        = 15'($urandom_range(32767));
        w.sy        = 15'($urandom_range(32767));
        pending_words.push_back(w);
        words_queued++;
        pixel_written[row * STORE_W + col] = 1'b1;
    endtask

    // Sample word, preceded by writes of any in-image neighbor not yet holding a
    // pixel, so that no unwritten entry is ever read.
    task automatic queue_sample(input logic [14:0] sx, input logic [14:0] sy);
        brs_pkg::brs_item_t s;
        int        c0, r0, col, row, n;
        c0 = sx >> FRAC_BITS;
        r0 = sy >> FRAC_BITS;
        for (n = 0; n < 4; n++)
        begin
            col = c0 + (n & 1);
            row = r0 + (n >> 1);
            if (col < eff_dim(img_width, STORE_W) && row < eff_dim(img_height, STORE_H)
                && !pixel_written[row * STORE_W + col])
                queue_write(col, row, $urandom);
        end
        s.is_sample = 1'b1;
        s.col       = 7'($urandom_range(127));
        s.row       = 7'($urandom_range(127));
        s.pixel     = $urandom;
        s.sx        = sx;
        s.sy        = sy;
        pending_words.push_back(s);
        words_queued++;
    endtask

    // Fractions lean on the extremes 0 and ONE-1.
    function automatic logic [7:0] pick_frac();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Random sample near the image (one in eight anywhere): corners may sit one past the
    // last column/row, so the right and lower neighbors fall outside.
    task automatic queue_random_sample();
        int          c0, r0;
        logic [14:0] sx, sy;
        c0 = $urandom_range(eff_dim(img_width, STORE_W));
        r0 = $urandom_range(eff_dim(img_height, STORE_H));
        if (c0 > STORE_W - 1)
            c0 = STORE_W - 1;
        if (r0 > STORE_H - 1)
            r0 = STORE_H - 1;
        sx = {c0[6:0], pick_frac()};
        sy = {r0[6:0], pick_frac()};
        if ($urandom_range(7) == 0)
        begin
            sx = 15'($urandom_range(32767));
            sy = 15'($urandom_range(32767));
        end
        queue_sample(sx, sy);
    endtask

    // Random write: half inside the image (when it is not empty), half anywhere in the store.
    task automatic queue_random_write();
        int w_eff, h_eff;
        w_eff = eff_dim(img_width, STORE_W);
        h_eff = eff_dim(img_height, STORE_H);
        if (w_eff > 0 && h_eff > 0 && $urandom_range(1) == 0)
            queue_write($urandom_range(w_eff - 1), $urandom_range(h_eff - 1), $urandom);
        else
            queue_write($urandom_range(127), $urandom_range(127), $urandom);
    endtask

    task automatic wait_for_results();
        while (pending_words.size() != 0 || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Register write on the config channel; the predictor dims follow at the
    // accepting edge. Only called with the sampler idle.
    task automatic write_register(input logic idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == brs_pkg::REG_IMAGE_WIDTH)
            img_width = data;
        else
            img_height = data;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: at the falling edge, hold the word on the ports until it is taken,
    // else present the next pending word unless this cycle idles.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || words_accepted == words_issued)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                start       <= 1'b1;
                action      <= pending_words[0].is_sample ? brs_pkg::ACT_SAMPLE
                                                          : brs_pkg::ACT_WRITE;
                write_col   <= pending_words[0].col;
                write_row   <= pending_words[0].row;
                write_red   <= pending_words[0].pixel[7:0];
                write_green <= pending_words[0].pixel[15:8];
                write_blue  <= pending_words[0].pixel[23:16];
                write_alpha <= pending_words[0].pixel[31:24];
                sample_x    <= pending_words[0].sx;
                sample_y    <= pending_words[0].sy;
                words_issued++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: at the rising edge, check a strobed result against the oldest
    // expectation, then take in an accepted word and update the predictor.
    always @(posedge clk)
    begin : monitor
        rgba_t got;
        rgba_t want;
        bit    bad;
        int    k;
        if (rst_n)
        begin
            if (result_valid)
            begin
                got = {out_alpha, out_blue, out_green, out_red};
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("ERROR: unexpected result rgba=%h at %0t", got, $realtime);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    bad  = 1'b0;
                    for (k = 0; k < 4; k++)
                    begin
                        if (got[8 * k +: 8] !== want[8 * k +: 8])
                        begin
                            bad = 1'b1;
                            if (errors < MAX_REPORTS)
                                $display("ERROR: %s expected %h got %h at %0t",
                                         chan_name[k], want[8 * k +: 8], got[8 * k +: 8],
                                         $realtime);
                        end
                    end
                    if (bad)
                        errors++;
                end
            end
            if (start && !busy)
            begin
                if (action == brs_pkg::ACT_SAMPLE)
                begin
                    expected_pixels.push_back(bilerp_pixel(sample_x, sample_y));
                    samples_taken++;
                end
                else
                begin
                    image_mem[{write_row, write_col}] =
                        {write_alpha, write_blue, write_green, write_red};
                    writes_taken++;
                end
                void'(pending_words.pop_front());
                words_accepted++;
            end
        end
    end

    // Watchdog: any handshake or result strobe counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
                $display("bilinear_rgba_sampler: mismatch");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        int phase_base;
        bit stopped;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Dims only change with nothing in flight, writes included.
            if (ph != 0)
            begin
                wait_for_results();
                repeat (DRAIN_CYCLES) @(posedge clk);
                write_register(brs_pkg::REG_IMAGE_WIDTH, phase_width[ph]);
                write_register(brs_pkg::REG_IMAGE_HEIGHT, phase_height[ph]);
            end
            idle_pct   = phase_idle[ph];
            phase_base = words_queued;
            stopped    = 1'b0;

            case (ph)
                0:
                begin
                    // channel extremes in the top-left 2x2 block and at two far corners
                    queue_write(0, 0, 32'hFFFF_FFFF);
                    queue_write(1, 0, 32'h0000_0000);
                    queue_write(0, 1, 32'h80FF_0001);
                    queue_write(1, 1, 32'h00FF_FF00);
                    queue_write(127, 0, 32'hFFFF_FFFF);
                    queue_write(0, 127, 32'h0000_0000);
                    queue_sample(15'h0000, 15'h0000);   // exact corner pixel
                    queue_sample(15'h00FF, 15'h00FF);   // max fractions
                    queue_sample(15'h0080, 15'h0040);
                    queue_sample(15'h0001, 15'h00FF);
                    queue_sample(15'h7FFF, 15'h7FFF);   // both far neighbors off the image
                    queue_sample(15'h7F80, 15'h0000);   // right edge
                    queue_sample(15'h0000, 15'h7F80);   // bottom edge
                end
                1:
                begin
                    // outside the 7x4 image but inside the store: kept for later
                    queue_write(10, 2, 32'hA5C3_5A3C);
                    queue_sample(15'h0680, 15'h0380);
                end
                2:
                begin
                    // zero width: every sample reads nothing
                    queue_sample(15'h0000, 15'h0000);
                    queue_sample(15'h7FFF, 15'h7FFF);
                end
                6:
                begin
                    // picks up the pixel written while the image was narrower
                    queue_sample({7'd9, 8'h80}, {7'd2, 8'h80});
                    queue_sample({7'd10, 8'h00}, {7'd2, 8'h00});
                end
                default:
                begin
                end
            endcase

            while (words_queued - phase_base < phase_words[ph])
            begin
                // one full stop mid-run: sender waits out every owed result
                if (ph == 2 && !stopped && words_queued - phase_base >= phase_words[ph] / 2)
                begin
                    wait_for_results();
                    stopped = 1'b1;
                end
                if ($urandom_range(9) < 3)
                    queue_random_write();
                else
                    queue_random_sample();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            errors++;

        $display("Run covered %0d samples and %0d pixel writes over %0d image shapes",
                 samples_taken, writes_taken, NUM_PHASES);
        $display("(%0d register writes, including zero and saturating dims)", cfg_writes);
        if (errors == 0)
            $display("bilinear_rgba_sampler: match");
        else
            $display("bilinear_rgba_sampler: mismatch");
        $finish;
    end

endmodule
